[rtl/nla_pkg.sv]
`default_nettype none
package nla_pkg;

	localparam int MAX_LANDMARKS_DEF = 64;
	localparam int COORD_BITS_DEF    = 24;
	localparam int FIELD_W           = COORD_BITS_DEF;
	localparam int INDEX_W           = 6;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		TK_NONE,
		TK_APPEND,
		TK_QUERY
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t kind;
		logic      have;
	} tok_ctl_t;

	typedef struct packed {
		logic [1:0]                operation;
		logic signed [FIELD_W-1:0] point_x;
		logic signed [FIELD_W-1:0] point_y;
	} item_t;

	typedef struct packed {
		logic [INDEX_W-1:0] nearest_index;
		logic               found;
	} result_t;

endpackage
`default_nettype wire

[rtl/nla_cell.sv]
`default_nettype none
module nla_cell #(
	parameter int MAX_LANDMARKS = nla_pkg::MAX_LANDMARKS_DEF,
	localparam int COORD_BITS   = nla_pkg::COORD_BITS_DEF,
	localparam int IDX_W        = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1,
	localparam int CNT_W        = $clog2(MAX_LANDMARKS + 1),
	localparam int D_W          = 2 * COORD_BITS + 2
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          adv,
	input  nla_pkg::tok_ctl_t            up_ctl,
	input  wire signed [COORD_BITS-1:0]  up_px,
	input  wire signed [COORD_BITS-1:0]  up_py,
	input  wire        [CNT_W-1:0]       up_rem,
	input  wire        [IDX_W-1:0]       up_pos,
	input  wire        [D_W-1:0]         up_bd,
	input  wire        [IDX_W-1:0]       up_bi,
	output nla_pkg::tok_ctl_t            dn_ctl,
	output logic signed [COORD_BITS-1:0] dn_px,
	output logic signed [COORD_BITS-1:0] dn_py,
	output logic        [CNT_W-1:0]      dn_rem,
	output logic        [IDX_W-1:0]      dn_pos,
	output logic        [D_W-1:0]        dn_bd,
	output logic        [IDX_W-1:0]      dn_bi
);
	import nla_pkg::*;

	logic signed [COORD_BITS-1:0] x_q, y_q;
	logic                         hit;
	logic                         act;
	logic signed [COORD_BITS:0]   dx, dy;
	logic signed [D_W-1:0]        sqx_full, sqy_full;

	tok_ctl_t                     ctl_s1, ctl_s2;
	logic                         act_s1;
	logic signed [COORD_BITS-1:0] px_s1, py_s1, px_s2, py_s2;
	logic [CNT_W-1:0]             rem_s1, rem_s2;
	logic [IDX_W-1:0]             pos_s1, pos_s2;
	logic [D_W-1:0]               bd_s1, bd_s2;
	logic [IDX_W-1:0]             bi_s1, bi_s2;
	logic [D_W-2:0]               sqx_s1, sqy_s1;

	logic [D_W-1:0]               dsq;
	logic                         upd;

	assign act = (up_rem != '0);
	assign hit = (up_ctl.kind == TK_APPEND) && !act;

	assign dx = {up_px[COORD_BITS-1], up_px} - {x_q[COORD_BITS-1], x_q};
	assign dy = {up_py[COORD_BITS-1], up_py} - {y_q[COORD_BITS-1], y_q};
	assign sqx_full = dx * dx;
	assign sqy_full = dy * dy;

	always_ff @(posedge clk) begin
		if (adv && hit) begin
			x_q <= up_px;
			y_q <= up_py;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '{kind: TK_NONE, have: 1'b0};
			act_s1 <= 1'b0;
			ctl_s2 <= '{kind: TK_NONE, have: 1'b0};
		end else if (adv) begin
			ctl_s1.kind <= hit ? TK_NONE : up_ctl.kind;
			ctl_s1.have <= up_ctl.have;
			act_s1      <= act;
			ctl_s2.kind <= ctl_s1.kind;
			ctl_s2.have <= ctl_s1.have | upd;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1  <= up_px;
			py_s1  <= up_py;
			rem_s1 <= act ? up_rem - CNT_W'(1) : up_rem;
			pos_s1 <= up_pos;
			bd_s1  <= up_bd;
			bi_s1  <= up_bi;
			sqx_s1 <= sqx_full[D_W-2:0];
			sqy_s1 <= sqy_full[D_W-2:0];

			px_s2  <= px_s1;
			py_s2  <= py_s1;
			rem_s2 <= rem_s1;
			pos_s2 <= pos_s1 + IDX_W'(1);
			bd_s2  <= upd ? dsq : bd_s1;
			bi_s2  <= upd ? pos_s1 : bi_s1;
		end
	end

	assign dsq = {1'b0, sqx_s1} + {1'b0, sqy_s1};
	assign upd = (ctl_s1.kind == TK_QUERY) && act_s1 && (!ctl_s1.have || (dsq < bd_s1));

	assign dn_ctl = ctl_s2;
	assign dn_px  = px_s2;
	assign dn_py  = py_s2;
	assign dn_rem = rem_s2;
	assign dn_pos = pos_s2;
	assign dn_bd  = bd_s2;
	assign dn_bi  = bi_s2;

endmodule
`default_nettype wire

[rtl/nearest_landmark_association.sv]
// A query word runs through the two pipeline stages of each cell, then the result register.
// Throughput: one word per cycle unless a stalled result word holds the pipeline.
// Clear and append words produce no result word.
// Reset empties the table and the pipeline; landmark coordinates stay undefined until written.
`default_nettype none
module nearest_landmark_association #(
	parameter int MAX_LANDMARKS = nla_pkg::MAX_LANDMARKS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              item_valid,
	output logic             item_stall,
	input  nla_pkg::item_t   item,
	output logic             result_valid,
	input  wire              result_stall,
	output nla_pkg::result_t result
);
	import nla_pkg::*;

	localparam int COORD_BITS = COORD_BITS_DEF;
	localparam int IDX_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
	localparam int CNT_W = $clog2(MAX_LANDMARKS + 1);
	localparam int D_W   = 2 * COORD_BITS + 2;

	logic                   adv;
	logic                   accept;
	logic [CNT_W-1:0]       count_q;
	logic                   result_valid_q;
	result_t                result_q;
	tok_ctl_t               inj_ctl;
	logic [COORD_BITS-1:0]  cx_raw, cy_raw;

	tok_ctl_t                     ch_ctl [0:MAX_LANDMARKS];
	logic signed [COORD_BITS-1:0] ch_px  [0:MAX_LANDMARKS];
	logic signed [COORD_BITS-1:0] ch_py  [0:MAX_LANDMARKS];
	logic [CNT_W-1:0]             ch_rem [0:MAX_LANDMARKS];
	logic [IDX_W-1:0]             ch_pos [0:MAX_LANDMARKS];
	logic [D_W-1:0]               ch_bd  [0:MAX_LANDMARKS];
	logic [IDX_W-1:0]             ch_bi  [0:MAX_LANDMARKS];

	assign adv        = !(result_valid_q && result_stall);
	assign item_stall = !adv;
	assign accept     = item_valid && adv;

	assign cx_raw = item.point_x;
	assign cy_raw = item.point_y;

	always_comb begin
		inj_ctl.kind = TK_NONE;
		inj_ctl.have = 1'b0;
		if (accept) begin
			unique case (item.operation)
				OP_APPEND: begin
					if (count_q < CNT_W'(MAX_LANDMARKS)) begin
						inj_ctl.kind = TK_APPEND;
					end
				end
				OP_QUERY: begin
					inj_ctl.kind = TK_QUERY;
				end
				default: begin
					inj_ctl.kind = TK_NONE;
				end
			endcase
		end
	end

	assign ch_ctl[0] = inj_ctl;
	assign ch_px[0]  = $signed(cx_raw);
	assign ch_py[0]  = $signed(cy_raw);
	assign ch_rem[0] = count_q;
	assign ch_pos[0] = '0;
	assign ch_bd[0]  = '0;
	assign ch_bi[0]  = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (item.operation == OP_CLEAR) begin
				count_q <= '0;
			end else if (item.operation == OP_APPEND && count_q < CNT_W'(MAX_LANDMARKS)) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	for (genvar i = 0; i < MAX_LANDMARKS; i++) begin : g_cell
		nla_cell #(
			.MAX_LANDMARKS (MAX_LANDMARKS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.up_ctl (ch_ctl[i]),
			.up_px  (ch_px[i]),
			.up_py  (ch_py[i]),
			.up_rem (ch_rem[i]),
			.up_pos (ch_pos[i]),
			.up_bd  (ch_bd[i]),
			.up_bi  (ch_bi[i]),
			.dn_ctl (ch_ctl[i+1]),
			.dn_px  (ch_px[i+1]),
			.dn_py  (ch_py[i+1]),
			.dn_rem (ch_rem[i+1]),
			.dn_pos (ch_pos[i+1]),
			.dn_bd  (ch_bd[i+1]),
			.dn_bi  (ch_bi[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= (ch_ctl[MAX_LANDMARKS].kind == TK_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ch_ctl[MAX_LANDMARKS].kind == TK_QUERY) begin
			result_q.found         <= ch_ctl[MAX_LANDMARKS].have;
			result_q.nearest_index <= INDEX_W'(ch_bi[MAX_LANDMARKS]);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

[rtl/nla_checker.sv]
`default_nettype none
module nla_checker (
	input wire              clk,
	input wire              arst_n,
	input wire              item_valid,
	input wire              item_stall,
	input nla_pkg::item_t   item,
	input wire              result_valid,
	input wire              result_stall,
	input nla_pkg::result_t result
);
	import nla_pkg::*;

	a_item_held: assert property (
		@(posedge clk) disable iff (!arst_n)
		(item_valid && item_stall) |=> (item_valid && $stable(item))
	) else $error("Stalled input word was withdrawn or changed.");

	a_stall_only_on_full_output: assert property (
		@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall)
	) else $error("Input stalled while the output side could take a word.");

	a_empty_index_zero: assert property (
		@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.found) |-> (result.nearest_index == '0)
	) else $error("Result without a landmark carries a nonzero index.");

	a_result_held: assert property (
		@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> result_valid
	) else $error("Stalled result word was dropped.");

	a_result_stable: assert property (
		@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> $stable(result)
	) else $error("Stalled result word changed.");

endmodule

bind nearest_landmark_association nla_checker u_nla_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
`default_nettype wire
